>>> src/fsau_pkg.sv
// Shared types, codes and constants of the Forth stack ALU unit.
// No dependencies; every other file imports this package.
package fsau_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned FUNC_W     = 6;
  localparam int unsigned DEPTH_W    = 7;
  localparam int unsigned RDEPTH_W   = 6;
  localparam int unsigned ERR_W      = 3;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned CELL_BYTES = 4;

  typedef enum logic [FUNC_W-1:0] {
    F_NOP = 6'd0, F_LIT, F_DROP, F_DUP, F_QDUP, F_SWAP, F_OVER, F_ROT, F_TUCK, F_NIP,
    F_TWO_DUP, F_TWO_DROP, F_TWO_SWAP, F_TWO_OVER, F_PICK, F_ROLL, F_DEPTH, F_TO_R,
    F_R_FROM, F_TWO_TO_R, F_TWO_R_FROM, F_I, F_J, F_ADD, F_SUB, F_MUL, F_DIV, F_INC,
    F_DEC, F_INC2, F_DEC2, F_NEGATE, F_ABS, F_LSHIFT, F_RSHIFT, F_AND, F_OR, F_XOR,
    F_MIN, F_MAX, F_EQ, F_NE, F_LT, F_GT, F_LE, F_GE, F_ZEQ, F_TRUE, F_FALSE, F_CELL,
    F_CELLS, F_ZBRANCH
  } func_e;

  typedef enum logic [ERR_W-1:0] {
    E_OK = 3'd0, E_DUNDER, E_DOVER, E_RET, E_DIVZ
  } err_e;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD0, S_RD1, S_RD2, S_RD3, S_DIV, S_ROLL_RD, S_ROLL_WR,
    S_WR0, S_WR1, S_WR2, S_FIN
  } state_e;

  typedef enum logic [1:0] {
    WS_TOP, WS_N1, WS_N3, WS_R2
  } wsrc_e;

  typedef struct packed {
    logic [1:0] dneed;
    logic [1:0] dgrow;
    logic [1:0] rneed;
    logic [1:0] rgrow;
  } need_t;

  typedef struct packed {
    logic              load;
    logic              check;
    logic              rd_iss;
    logic [SLOT_W-1:0] iss_slot;
    logic              rd_cap;
    logic [SLOT_W-1:0] cap_slot;
    logic              div_start;
    logic              roll_rd;
    logic              roll_wr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic              commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fault;
    logic is_div;
    logic is_roll;
    logic div_done;
    logic roll_done;
  } dp_status_t;

  function automatic need_t op_need(func_e f);
    need_t n;
    n = '0;
    unique case (f)
      F_LIT, F_DUP, F_DEPTH, F_TRUE, F_FALSE, F_CELL: n.dgrow = 2'd1;
      F_DROP, F_SWAP, F_NIP, F_ZBRANCH:               n.dneed = 2'd1;
      F_OVER, F_TUCK: begin
        n.dneed = 2'd1;
        n.dgrow = 2'd1;
      end
      F_ROT, F_TWO_DROP: n.dneed = 2'd2;
      F_TWO_DUP: begin
        n.dneed = 2'd1;
        n.dgrow = 2'd2;
      end
      F_TWO_SWAP: n.dneed = 2'd3;
      F_TWO_OVER: begin
        n.dneed = 2'd3;
        n.dgrow = 2'd2;
      end
      F_TO_R: begin
        n.dneed = 2'd1;
        n.rgrow = 2'd1;
      end
      F_R_FROM, F_I: begin
        n.dgrow = 2'd1;
        n.rneed = 2'd1;
      end
      F_TWO_TO_R: begin
        n.dneed = 2'd2;
        n.rgrow = 2'd2;
      end
      F_TWO_R_FROM: begin
        n.dgrow = 2'd2;
        n.rneed = 2'd2;
      end
      F_J: begin
        n.dgrow = 2'd1;
        n.rneed = 2'd3;
      end
      F_ADD, F_SUB, F_MUL, F_DIV, F_LSHIFT, F_RSHIFT, F_AND, F_OR, F_XOR, F_MIN, F_MAX,
      F_EQ, F_NE, F_LT, F_GT, F_LE, F_GE: n.dneed = 2'd1;
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

>>> src/fsau_in_if.sv
// Request channel of the Forth stack ALU unit: valid/ready plus primitive code and literal.
// Depends on fsau_pkg.
interface fsau_in_if import fsau_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] literal;

  modport source (output valid, output func, output literal, input ready);
  modport sink (input valid, input func, input literal, output ready);
endinterface

>>> src/fsau_out_if.sv
// Result channel of the Forth stack ALU unit: valid/ready plus top, depths, branch and error.
// Depends on fsau_pkg.
interface fsau_out_if import fsau_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top;
  logic [DEPTH_W-1:0]       depth;
  logic [RDEPTH_W-1:0]      return_depth;
  logic                     branch_taken;
  logic [ERR_W-1:0]         error;

  modport source (output valid, output top, output depth, output return_depth,
                  output branch_taken, output error, input ready);
  modport sink (input valid, input top, input depth, input return_depth,
                input branch_taken, input error, output ready);
endinterface

>>> src/fsau_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on fsau_pkg.
module fsau_div import fsau_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quotient_o
);
  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] mag_b_q;
  logic [DATA_W:0]   trial;

  assign trial      = {rem_q, quo_q[DATA_W-1]} - {1'b0, mag_b_q};
  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DATA_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= '0;
      quo_q   <= dividend_i[DATA_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      mag_b_q <= divisor_i[DATA_W-1] ? (~divisor_i + 1'b1) : divisor_i;
      neg_q   <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
    end else if (busy_q) begin
      if (!trial[DATA_W]) begin
        rem_q <= trial[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end
endmodule

>>> src/fsau_dpath.sv
// Datapath: top register, stack pointers, both stack memories, fault check and ALU.
// Depends on fsau_pkg and fsau_div; driven by fsau_ctrl through ctrl_cmd_t.
module fsau_dpath import fsau_pkg::*; #(
  parameter int unsigned DATA_DEPTH   = 64,
  parameter int unsigned RETURN_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [DATA_W-1:0]   literal_i,
  output logic [DATA_W-1:0]   top_o,
  output logic [DEPTH_W-1:0]  depth_o,
  output logic [RDEPTH_W-1:0] return_depth_o,
  output logic                branch_taken_o,
  output logic [ERR_W-1:0]    error_o
);
  localparam int unsigned DPW  = $clog2(DATA_DEPTH + 1);
  localparam int unsigned DAW  = $clog2(DATA_DEPTH);
  localparam int unsigned RPW  = $clog2(RETURN_DEPTH + 1);
  localparam int unsigned RAW  = $clog2(RETURN_DEPTH);
  localparam int unsigned DPW1 = DPW + 1;
  localparam int unsigned RPW1 = RPW + 1;

  func_e             func_q;
  logic [DATA_W-1:0] lit_q, top_q, n1_q, n2_q, n3_q, r1_q, r2_q, r3_q;
  logic [DPW-1:0]    dp_q, cursor_q;
  logic [RPW-1:0]    rp_q;
  err_e              err_q, err_n;

  logic [DATA_W-1:0] dmem [DATA_DEPTH];
  logic [DATA_W-1:0] rmem [RETURN_DEPTH];
  logic [DATA_W-1:0] d_rd_q, r_rd_q;

  need_t             nd;
  logic [1:0]        dgrow;
  logic [DPW-1:0]    pick_idx, d_raddr_w, d_waddr_w;
  logic [RPW-1:0]    r_raddr_w, r_waddr_w;
  logic              d_we, r_we, d_we_slot, r_we_slot;
  logic signed [2:0] d_off, r_off, d_delta, r_delta;
  wsrc_e             d_src, r_src;
  logic [DATA_W-1:0] d_wdata, r_wdata;
  logic [DATA_W-1:0] top_n, mul_lo, quo;
  logic [DPW-1:0]    dp_n;
  logic [RPW-1:0]    rp_n;
  logic              div_done, lt_nt, lt_tn;

  fsau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (n1_q),
    .divisor_i  (top_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // fault check, in priority order
  always_comb begin
    nd    = op_need(func_q);
    dgrow = nd.dgrow;
    if (func_q == F_QDUP && top_q != '0) dgrow = 2'd1;
    priority if (dp_q < DPW'(nd.dneed)) err_n = E_DUNDER;
    else if ((func_q == F_PICK || func_q == F_ROLL) && top_q >= DATA_W'(dp_q))
      err_n = E_DUNDER;
    else if (DPW1'(dp_q) + DPW1'(dgrow) > DPW1'(DATA_DEPTH)) err_n = E_DOVER;
    else if (rp_q < RPW'(nd.rneed) ||
             RPW1'(rp_q) + RPW1'(nd.rgrow) > RPW1'(RETURN_DEPTH)) err_n = E_RET;
    else if (func_q == F_DIV && top_q == '0) err_n = E_DIVZ;
    else err_n = E_OK;
  end

  assign pick_idx            = dp_q - DPW'(1) - top_q[DPW-1:0];
  assign status_o.fault      = err_n != E_OK;
  assign status_o.is_div     = func_q == F_DIV;
  assign status_o.is_roll    = func_q == F_ROLL;
  assign status_o.div_done   = div_done;
  assign status_o.roll_done  = cursor_q == dp_q - DPW'(1);

  // stack write slots
  always_comb begin
    d_we_slot = 1'b0;
    d_off     = '0;
    d_src     = WS_TOP;
    r_we_slot = 1'b0;
    r_off     = '0;
    r_src     = WS_TOP;
    unique case (func_q)
      F_LIT, F_DUP, F_OVER, F_DEPTH, F_R_FROM, F_I, F_J, F_TRUE, F_FALSE, F_CELL:
        d_we_slot = cmd_i.wr_slot == 2'd0;
      F_QDUP: d_we_slot = cmd_i.wr_slot == 2'd0 && top_q != '0;
      F_SWAP: begin
        d_we_slot = cmd_i.wr_slot == 2'd0;
        d_off     = -3'sd1;
      end
      F_ROT: begin
        d_we_slot = cmd_i.wr_slot != 2'd2;
        d_off     = (cmd_i.wr_slot == 2'd0) ? -3'sd2 : -3'sd1;
        d_src     = (cmd_i.wr_slot == 2'd0) ? WS_N1 : WS_TOP;
      end
      F_TUCK: begin
        d_we_slot = cmd_i.wr_slot != 2'd2;
        d_off     = (cmd_i.wr_slot == 2'd0) ? -3'sd1 : 3'sd0;
        d_src     = (cmd_i.wr_slot == 2'd0) ? WS_TOP : WS_N1;
      end
      F_TWO_DUP, F_TWO_OVER, F_TWO_R_FROM: begin
        d_we_slot = cmd_i.wr_slot != 2'd2;
        d_off     = (cmd_i.wr_slot == 2'd0) ? 3'sd0 : 3'sd1;
        if (cmd_i.wr_slot != 2'd0) begin
          d_src = (func_q == F_TWO_DUP) ? WS_N1 : (func_q == F_TWO_OVER) ? WS_N3 : WS_R2;
        end
      end
      F_TWO_SWAP: begin
        d_we_slot = cmd_i.wr_slot != 2'd3;
        unique case (cmd_i.wr_slot)
          2'd0: begin
            d_off = -3'sd3;
            d_src = WS_N1;
          end
          2'd1: d_off = -3'sd2;
          default: begin
            d_off = -3'sd1;
            d_src = WS_N3;
          end
        endcase
      end
      F_TO_R: r_we_slot = cmd_i.wr_slot == 2'd0;
      F_TWO_TO_R: begin
        r_we_slot = cmd_i.wr_slot != 2'd2;
        r_off     = (cmd_i.wr_slot == 2'd0) ? 3'sd0 : 3'sd1;
        r_src     = (cmd_i.wr_slot == 2'd0) ? WS_N1 : WS_TOP;
      end
      default: ;
    endcase
  end

  function automatic logic [DATA_W-1:0] wsel(wsrc_e s, logic [DATA_W-1:0] t,
                                             logic [DATA_W-1:0] a, logic [DATA_W-1:0] c,
                                             logic [DATA_W-1:0] r);
    logic [DATA_W-1:0] v;
    unique case (s)
      WS_TOP:  v = t;
      WS_N1:   v = a;
      WS_N3:   v = c;
      default: v = r;
    endcase
    return v;
  endfunction

  always_comb begin
    d_we      = cmd_i.roll_wr || (cmd_i.wr_en && d_we_slot);
    r_we      = cmd_i.wr_en && r_we_slot;
    d_waddr_w = cmd_i.roll_wr ? cursor_q : dp_q + DPW'(d_off);
    d_wdata   = cmd_i.roll_wr ? d_rd_q : wsel(d_src, top_q, n1_q, n3_q, r2_q);
    r_waddr_w = rp_q + RPW'(r_off);
    r_wdata   = wsel(r_src, top_q, n1_q, n3_q, r2_q);
    if (cmd_i.roll_rd) d_raddr_w = cursor_q + DPW'(1);
    else if (cmd_i.iss_slot == '0 && (func_q == F_PICK || func_q == F_ROLL))
      d_raddr_w = pick_idx;
    else d_raddr_w = dp_q - DPW'(1) - DPW'(cmd_i.iss_slot);
    r_raddr_w = rp_q - RPW'(1) - RPW'(cmd_i.iss_slot);
  end

  always_ff @(posedge clk_i) begin
    if (d_we) dmem[d_waddr_w[DAW-1:0]] <= d_wdata;
    if (cmd_i.rd_iss || cmd_i.roll_rd) d_rd_q <= dmem[d_raddr_w[DAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (r_we) rmem[r_waddr_w[RAW-1:0]] <= r_wdata;
    if (cmd_i.rd_iss) r_rd_q <= rmem[r_raddr_w[RAW-1:0]];
  end

  // next top and pointer moves
  assign mul_lo = n1_q * top_q;
  assign lt_nt  = $signed(n1_q) < $signed(top_q);
  assign lt_tn  = $signed(top_q) < $signed(n1_q);

  always_comb begin
    top_n   = top_q;
    d_delta = '0;
    r_delta = '0;
    unique case (func_q)
      F_LIT:  begin top_n = lit_q;        d_delta = 3'sd1; end
      F_DROP: begin top_n = n1_q;         d_delta = -3'sd1; end
      F_DUP, F_TUCK: d_delta = 3'sd1;
      F_QDUP: d_delta = (top_q != '0) ? 3'sd1 : 3'sd0;
      F_SWAP: top_n = n1_q;
      F_OVER: begin top_n = n1_q;         d_delta = 3'sd1; end
      F_ROT, F_TWO_SWAP: top_n = n2_q;
      F_NIP:  d_delta = -3'sd1;
      F_TWO_DUP: d_delta = 3'sd2;
      F_TWO_DROP: begin top_n = n2_q;     d_delta = -3'sd2; end
      F_TWO_OVER: begin top_n = n2_q;     d_delta = 3'sd2; end
      F_PICK: top_n = n1_q;
      F_ROLL: begin top_n = n1_q;         d_delta = -3'sd1; end
      F_DEPTH: begin top_n = DATA_W'(dp_q); d_delta = 3'sd1; end
      F_TO_R: begin top_n = n1_q; d_delta = -3'sd1; r_delta = 3'sd1; end
      F_R_FROM: begin top_n = r1_q; d_delta = 3'sd1; r_delta = -3'sd1; end
      F_TWO_TO_R: begin top_n = n2_q; d_delta = -3'sd2; r_delta = 3'sd2; end
      F_TWO_R_FROM: begin top_n = r1_q; d_delta = 3'sd2; r_delta = -3'sd2; end
      F_I:    begin top_n = r1_q;         d_delta = 3'sd1; end
      F_J:    begin top_n = r3_q;         d_delta = 3'sd1; end
      F_ADD:  begin top_n = n1_q + top_q; d_delta = -3'sd1; end
      F_SUB:  begin top_n = n1_q - top_q; d_delta = -3'sd1; end
      F_MUL:  begin top_n = mul_lo;       d_delta = -3'sd1; end
      F_DIV:  begin top_n = quo;          d_delta = -3'sd1; end
      F_INC:  top_n = top_q + DATA_W'(1);
      F_DEC:  top_n = top_q - DATA_W'(1);
      F_INC2: top_n = top_q + DATA_W'(2);
      F_DEC2: top_n = top_q - DATA_W'(2);
      F_NEGATE: top_n = ~top_q + 1'b1;
      F_ABS:  top_n = top_q[DATA_W-1] ? (~top_q + 1'b1) : top_q;
      F_LSHIFT: begin
        top_n   = (top_q < DATA_W'(DATA_W)) ? (n1_q << top_q[4:0]) : '0;
        d_delta = -3'sd1;
      end
      F_RSHIFT: begin
        top_n   = (top_q < DATA_W'(DATA_W)) ? (n1_q >> top_q[4:0]) : '0;
        d_delta = -3'sd1;
      end
      F_AND:  begin top_n = n1_q & top_q; d_delta = -3'sd1; end
      F_OR:   begin top_n = n1_q | top_q; d_delta = -3'sd1; end
      F_XOR:  begin top_n = n1_q ^ top_q; d_delta = -3'sd1; end
      F_MIN:  begin top_n = lt_tn ? top_q : n1_q; d_delta = -3'sd1; end
      F_MAX:  begin top_n = lt_nt ? top_q : n1_q; d_delta = -3'sd1; end
      F_EQ:   begin top_n = {DATA_W{n1_q == top_q}}; d_delta = -3'sd1; end
      F_NE:   begin top_n = {DATA_W{n1_q != top_q}}; d_delta = -3'sd1; end
      F_LT:   begin top_n = {DATA_W{lt_nt}};  d_delta = -3'sd1; end
      F_GT:   begin top_n = {DATA_W{lt_tn}};  d_delta = -3'sd1; end
      F_LE:   begin top_n = {DATA_W{!lt_tn}}; d_delta = -3'sd1; end
      F_GE:   begin top_n = {DATA_W{!lt_nt}}; d_delta = -3'sd1; end
      F_ZEQ:  top_n = {DATA_W{top_q == '0}};
      F_TRUE: begin top_n = '1;           d_delta = 3'sd1; end
      F_FALSE: begin top_n = '0;          d_delta = 3'sd1; end
      F_CELL: begin top_n = DATA_W'(CELL_BYTES); d_delta = 3'sd1; end
      F_CELLS: top_n = top_q << 2;
      F_ZBRANCH: begin top_n = n1_q;      d_delta = -3'sd1; end
      default: top_n = top_q;
    endcase
    dp_n = dp_q + DPW'(d_delta);
    rp_n = rp_q + RPW'(r_delta);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      dp_q  <= '0;
      rp_q  <= '0;
    end else if (cmd_i.commit && err_q == E_OK) begin
      top_q <= top_n;
      dp_q  <= dp_n;
      rp_q  <= rp_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= (func_i > FUNC_W'(F_ZBRANCH)) ? F_NOP : func_e'(func_i);
      lit_q  <= literal_i;
    end
    if (cmd_i.check) begin
      err_q    <= err_n;
      cursor_q <= pick_idx;
    end else if (cmd_i.roll_wr) begin
      cursor_q <= cursor_q + DPW'(1);
    end
    if (cmd_i.rd_cap) begin
      unique case (cmd_i.cap_slot)
        2'd0: begin
          n1_q <= d_rd_q;
          r1_q <= r_rd_q;
        end
        2'd1: begin
          n2_q <= d_rd_q;
          r2_q <= r_rd_q;
        end
        default: begin
          n3_q <= d_rd_q;
          r3_q <= r_rd_q;
        end
      endcase
    end
    if (cmd_i.commit) begin
      error_o        <= err_q;
      branch_taken_o <= err_q == E_OK && func_q == F_ZBRANCH && top_q == '0;
      if (err_q == E_OK) begin
        top_o          <= top_n;
        depth_o        <= DEPTH_W'(dp_n);
        return_depth_o <= RDEPTH_W'(rp_n);
      end else begin
        top_o          <= top_q;
        depth_o        <= DEPTH_W'(dp_q);
        return_depth_o <= RDEPTH_W'(rp_q);
      end
    end
  end
endmodule

>>> src/fsau_ctrl.sv
// Sequencer: steps one request through check, stack reads, divide or roll, writes and result.
// Depends on fsau_pkg; drives fsau_dpath through ctrl_cmd_t.
module fsau_ctrl import fsau_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);
  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_free   = !out_valid_q || out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.fault ? S_FIN : S_RD0;
      end
      S_RD0: begin
        cmd_o.rd_iss   = 1'b1;
        cmd_o.iss_slot = 2'd0;
        state_d        = S_RD1;
      end
      S_RD1: begin
        cmd_o.rd_iss   = 1'b1;
        cmd_o.iss_slot = 2'd1;
        cmd_o.rd_cap   = 1'b1;
        cmd_o.cap_slot = 2'd0;
        state_d        = S_RD2;
      end
      S_RD2: begin
        cmd_o.rd_iss   = 1'b1;
        cmd_o.iss_slot = 2'd2;
        cmd_o.rd_cap   = 1'b1;
        cmd_o.cap_slot = 2'd1;
        state_d        = S_RD3;
      end
      S_RD3: begin
        cmd_o.rd_cap   = 1'b1;
        cmd_o.cap_slot = 2'd2;
        if (status_i.is_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else if (status_i.is_roll) begin
          state_d = S_ROLL_RD;
        end else begin
          state_d = S_WR0;
        end
      end
      S_DIV: if (status_i.div_done) state_d = S_WR0;
      S_ROLL_RD: begin
        if (status_i.roll_done) begin
          state_d = S_WR0;
        end else begin
          cmd_o.roll_rd = 1'b1;
          state_d       = S_ROLL_WR;
        end
      end
      S_ROLL_WR: begin
        cmd_o.roll_wr = 1'b1;
        state_d       = S_ROLL_RD;
      end
      S_WR0: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_slot = 2'd0;
        state_d       = S_WR1;
      end
      S_WR1: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_slot = 2'd1;
        state_d       = S_WR2;
      end
      S_WR2: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_slot = 2'd2;
        state_d       = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.commit;
  end
endmodule

>>> src/forth_stack_alu_unit.sv
// Top level of the Forth stack ALU unit: sequencer plus datapath behind two valid/ready channels.
// Depends on fsau_pkg, fsau_in_if, fsau_out_if, fsau_ctrl and fsau_dpath.
//
// Each request runs one Forth primitive on the top-of-stack register, the data stack and the
// return stack, and yields exactly one result. Requests are taken one at a time: a request
// accepted in the idle state goes through the check, the reads through the single read port
// of each stack memory, the writes and the result. A divide adds a pass through the
// one-bit-per-cycle divider; a roll with index n adds the element shift through the same
// memory port. A finished result waits in the output register while the next request is
// accepted and worked on. A faulting request skips the stack phases and leaves the stacks,
// their pointers and the top register untouched. The stacks need no clearing after reset.
module forth_stack_alu_unit import fsau_pkg::*; #(
  parameter int unsigned DATA_DEPTH   = 64,
  parameter int unsigned RETURN_DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fsau_in_if.sink   in_i,
  fsau_out_if.source out_o
);
  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic [DATA_W-1:0] top;

  fsau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fsau_dpath #(
    .DATA_DEPTH   (DATA_DEPTH),
    .RETURN_DEPTH (RETURN_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .func_i         (in_i.func),
    .literal_i      (in_i.literal),
    .top_o          (top),
    .depth_o        (out_o.depth),
    .return_depth_o (out_o.return_depth),
    .branch_taken_o (out_o.branch_taken),
    .error_o        (out_o.error)
  );

  assign out_o.top = $signed(top);
endmodule
